FILE: rtl/core/adsid_pkg.sv
// shared widths, codes and reset values for the audio drift corrector
`timescale 1ns / 1ps
package adsid_pkg;

	// payload widths
	localparam int SAMPLE_W   = 16;
	localparam int CMD_W      = 2;
	localparam int PCT_W      = 7;
	localparam int LEVEL_W    = 8;
	localparam int GAIN_W     = 9;
	localparam int PERIOD_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// filter number format: doubled percent with fraction bits below
	localparam int FRAC_BITS  = 8;
	localparam int FILT_W     = LEVEL_W + FRAC_BITS;
	localparam int GAIN_FRAC  = 8;
	localparam int PROD_W     = GAIN_W + FILT_W;

	// item commands
	localparam logic [CMD_W-1:0] CMD_FRAME   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd6;

	// register reset values
	localparam logic [LEVEL_W-1:0]  RST_LOW    = 8'd20;
	localparam logic [LEVEL_W-1:0]  RST_HIGH   = 8'd95;
	localparam logic [LEVEL_W-1:0]  RST_TARGET = 8'd60;
	localparam logic [LEVEL_W-1:0]  RST_START  = 8'd40;
	localparam logic [GAIN_W-1:0]   RST_GAIN   = 9'd51;
	localparam logic [PERIOD_W-1:0] RST_PERIOD = 16'd1024;

endpackage

FILE: rtl/core/adsid_if.sv
// item channels and register write channel of the audio drift corrector
`timescale 1ns / 1ps
interface adsid_in_if;
	import adsid_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [CMD_W-1:0]           command;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic [PCT_W-1:0]           fill_percent;

	modport source (output valid, command, left_sample, right_sample, fill_percent,
		input ready);
	modport sink (input valid, command, left_sample, right_sample, fill_percent,
		output ready);
endinterface

interface adsid_out_if;
	import adsid_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_left;
	logic signed [SAMPLE_W-1:0] out_right;
	logic                       frame_valid;
	logic                       last_of_run;
	logic [LEVEL_W-1:0]         fill_smoothed;
	logic signed [1:0]          fill_grade;
	logic signed [1:0]          correction_dir;

	modport source (output valid, out_left, out_right, frame_valid, last_of_run,
		fill_smoothed, fill_grade, correction_dir, input ready);
	modport sink (input valid, out_left, out_right, frame_valid, last_of_run,
		fill_smoothed, fill_grade, correction_dir, output ready);
endinterface

interface adsid_cfg_if;
	import adsid_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/audio_drift_sample_insert_drop_top.sv
// audio drift corrector: fill smoothing, mode machine and frame insert or drop
// path: an item waits in the input register and its result is then loaded into the
//   result register, which drives the result port; a busy result register stalls the item
// throughput: one item per cycle while the result port accepts; a duplicated frame holds
//   the result register for two transfers and stalls the input register meanwhile
// reset: arst_n clears mode, filter, grade, phase and all valid flags at once,
//   and loads the registers with their default values (channel disabled)
`timescale 1ns / 1ps
module audio_drift_sample_insert_drop_top (
	input  logic          clk,
	input  logic          arst_n,
	adsid_in_if.sink      item,
	adsid_out_if.source   result,
	adsid_cfg_if.sink     cfg
);
	import adsid_pkg::*;

	// adaptation modes
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_HOLD   = 2'd1;
	localparam logic [1:0] MODE_ADD    = 2'd2;
	localparam logic [1:0] MODE_REMOVE = 2'd3;

	localparam logic signed [1:0] GRADE_LOW  = -2'sd1;
	localparam logic signed [1:0] GRADE_OK   = 2'sd0;
	localparam logic signed [1:0] GRADE_HIGH = 2'sd1;

	localparam logic [PCT_W-1:0]    PCT_MAX    = 7'd100;
	localparam logic [GAIN_W-1:0]   GAIN_ONE   = GAIN_W'(1 << GAIN_FRAC);
	localparam logic [PROD_W-1:0]   ROUND_HALF = PROD_W'(1 << (GAIN_FRAC - 1));
	localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd2;
	localparam logic [FILT_W-1:0]   FILT_MAX   = FILT_W'(200 << FRAC_BITS);

	// configuration registers
	logic                enable_q;
	logic [LEVEL_W-1:0]  low_q, high_q, target_q, start_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [PERIOD_W-1:0] period_q;

	// block state
	logic [1:0]          mode_q;
	logic [FILT_W-1:0]   filt_q;
	logic signed [1:0]   grade_q;
	logic [PERIOD_W-1:0] phase_q;

	// input register
	logic                       v_s1;
	logic [CMD_W-1:0]           cmd_s1;
	logic signed [SAMPLE_W-1:0] left_s1, right_s1;
	logic [PCT_W-1:0]           pct_s1;

	// result register, dup_q marks a frame that goes out a second time
	logic                       out_v_q;
	logic                       dup_q;
	logic signed [SAMPLE_W-1:0] out_left_q, out_right_q;
	logic                       frame_q, last_q;
	logic [LEVEL_W-1:0]         smooth_q;
	logic signed [1:0]          grade_out_q, dir_out_q;

	logic go;
	logic out_take;

	// filter datapath
	logic [PCT_W-1:0]  pct_sat;
	logic [FILT_W-1:0] x_lvl, diff, step, filt_meas;
	logic [GAIN_W-1:0] gain_eff;
	logic              rising;
	logic [PROD_W-1:0] prod, prod_rnd;
	logic signed [1:0] grade_meas;
	logic [1:0]        mode_meas;

	// next state and result of the item in the input register
	logic [1:0]          mode_nxt;
	logic [FILT_W-1:0]   filt_nxt;
	logic signed [1:0]   grade_nxt;
	logic [PERIOD_W-1:0] phase_nxt;
	logic [PERIOD_W-1:0] period_eff;
	logic [PERIOD_W:0]   phase_inc;
	logic                emit, emit_frame, emit_dup;
	logic signed [1:0]   dir_nxt;

	assign cfg.ready  = 1'b1;
	assign out_take   = out_v_q && result.ready;
	// the item moves on once the result register is free or being emptied
	assign go         = v_s1 && (!out_v_q || (result.ready && !dup_q));
	assign item.ready = !v_s1 || go;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			low_q    <= RST_LOW;
			high_q   <= RST_HIGH;
			target_q <= RST_TARGET;
			start_q  <= RST_START;
			gain_q   <= RST_GAIN;
			period_q <= RST_PERIOD;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ENABLE: enable_q <= cfg.data[0];
				REG_LOW:    low_q    <= cfg.data[LEVEL_W-1:0];
				REG_HIGH:   high_q   <= cfg.data[LEVEL_W-1:0];
				REG_TARGET: target_q <= cfg.data[LEVEL_W-1:0];
				REG_START:  start_q  <= cfg.data[LEVEL_W-1:0];
				REG_GAIN:   gain_q   <= cfg.data[GAIN_W-1:0];
				REG_PERIOD: period_q <= cfg.data[PERIOD_W-1:0];
				default:    ; // unused indexes are dropped
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1   <= item.command;
			left_s1  <= item.left_sample;
			right_s1 <= item.right_sample;
			pct_s1   <= item.fill_percent;
		end
	end

	// exponential filter step, rounded half away from zero
	always_comb begin
		pct_sat  = (pct_s1 > PCT_MAX) ? PCT_MAX : pct_s1;
		x_lvl    = {pct_sat, 1'b0, {FRAC_BITS{1'b0}}};
		gain_eff = (mode_q == MODE_IDLE || gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
		rising   = (x_lvl >= filt_q);
		diff     = rising ? (x_lvl - filt_q) : (filt_q - x_lvl);
		prod     = PROD_W'(gain_eff) * PROD_W'(diff);
		prod_rnd = prod + ROUND_HALF;
		step     = prod_rnd[GAIN_FRAC +: FILT_W];
		filt_meas = rising ? (filt_q + step) : (filt_q - step);

		if (filt_meas < {low_q, {FRAC_BITS{1'b0}}}) begin
			grade_meas = GRADE_LOW;
		end else if (filt_meas > {high_q, {FRAC_BITS{1'b0}}}) begin
			grade_meas = GRADE_HIGH;
		end else begin
			grade_meas = GRADE_OK;
		end

		// hysteresis between the limits and the target level; idle waits for the start level
		mode_meas = mode_q;
		unique case (mode_q)
			MODE_HOLD: begin
				if (grade_meas == GRADE_LOW) begin
					mode_meas = MODE_ADD;
				end else if (grade_meas == GRADE_HIGH) begin
					mode_meas = MODE_REMOVE;
				end
			end
			MODE_REMOVE: begin
				if (filt_meas <= {target_q, {FRAC_BITS{1'b0}}}) mode_meas = MODE_HOLD;
			end
			MODE_ADD: begin
				if (filt_meas >= {target_q, {FRAC_BITS{1'b0}}}) mode_meas = MODE_HOLD;
			end
			MODE_IDLE: begin
				if (filt_meas >= {start_q, {FRAC_BITS{1'b0}}}) mode_meas = MODE_HOLD;
			end
			default: ;
		endcase
	end

	// per-command state update and result selection
	always_comb begin
		mode_nxt   = mode_q;
		filt_nxt   = filt_q;
		grade_nxt  = grade_q;
		phase_nxt  = phase_q;
		emit       = 1'b0;
		emit_frame = 1'b0;
		emit_dup   = 1'b0;
		period_eff = (period_q < PERIOD_MIN) ? PERIOD_MIN : period_q;
		phase_inc  = {1'b0, phase_q} + 1'b1;

		if (enable_q) begin
			priority case (cmd_s1)
				CMD_MEASURE: begin
					mode_nxt  = mode_meas;
					filt_nxt  = filt_meas;
					grade_nxt = grade_meas;
					emit      = 1'b1;
				end
				CMD_RESTART: begin
					mode_nxt  = MODE_IDLE;
					filt_nxt  = '0;
					phase_nxt = '0;
					emit      = 1'b1;
				end
				CMD_FRAME: begin
					emit_frame = 1'b1;
					if (mode_q == MODE_ADD || mode_q == MODE_REMOVE) begin
						// phase wraps also when a smaller period left it beyond the end
						phase_nxt = (phase_inc >= {1'b0, period_eff}) ? '0
							: phase_inc[PERIOD_W-1:0];
						if (phase_q == '0) begin
							emit     = (mode_q == MODE_ADD);
							emit_dup = (mode_q == MODE_ADD);
						end else begin
							emit = 1'b1;
						end
					end else begin
						emit = 1'b1;
					end
				end
				default: ; // unused command code
			endcase
		end

		unique case (mode_nxt)
			MODE_ADD:    dir_nxt = 2'sd1;
			MODE_REMOVE: dir_nxt = -2'sd1;
			default:     dir_nxt = 2'sd0;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			filt_q  <= '0;
			grade_q <= GRADE_OK;
			phase_q <= '0;
		end else if (go) begin
			mode_q  <= mode_nxt;
			filt_q  <= filt_nxt;
			grade_q <= grade_nxt;
			phase_q <= phase_nxt;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			dup_q   <= 1'b0;
			last_q  <= 1'b0;
		end else if (go && emit) begin
			out_v_q <= 1'b1;
			dup_q   <= emit_dup;
			last_q  <= !emit_dup;
		end else if (out_take && dup_q) begin
			// second copy of an inserted frame closes the run
			dup_q  <= 1'b0;
			last_q <= 1'b1;
		end else if (out_take) begin
			out_v_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_left_q  <= emit_frame ? left_s1 : '0;
			out_right_q <= emit_frame ? right_s1 : '0;
			frame_q     <= emit_frame;
			smooth_q    <= filt_nxt[FILT_W-1:FRAC_BITS];
			grade_out_q <= grade_nxt;
			dir_out_q   <= dir_nxt;
		end
	end

	assign result.valid          = out_v_q;
	assign result.out_left       = out_left_q;
	assign result.out_right      = out_right_q;
	assign result.frame_valid    = frame_q;
	assign result.last_of_run    = last_q;
	assign result.fill_smoothed  = smooth_q;
	assign result.fill_grade     = grade_out_q;
	assign result.correction_dir = dir_out_q;

	// a pending second copy always sits in a valid result register
	a_dup_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dup_q |-> (out_v_q && frame_q && !last_q))
		else $error("pending frame copy without valid result");

	// only the first copy of an inserted frame leaves the run open
	a_open_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.last_of_run) |-> (result.frame_valid && dup_q))
		else $error("open run on a result that is not a duplicated frame");

	// the smoothed level never passes the doubled full-scale value
	a_filt_range: assert property (@(posedge clk) disable iff (!arst_n)
		filt_q <= FILT_MAX)
		else $error("fill filter above full scale");

	// a restart reports an empty filter and no correction
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(go && enable_q && cmd_s1 == CMD_RESTART) |=>
		(out_v_q && smooth_q == '0 && dir_out_q == 2'sd0 && mode_q == MODE_IDLE))
		else $error("restart left filter or mode set");

endmodule
